// File: hw/rtl/tcprq_pkg.sv
// ----------------------------------------------------------------------------
// tcprq_pkg
// Shared types and constants for the three-class priority ray queue.
// ----------------------------------------------------------------------------
package tcprq_pkg;

	// Default queue depth and handle width.
	localparam int unsigned DefQueueDepth = 256;
	localparam int unsigned DefHandleBits = 16;

	// Width of the reported queue counts.
	localparam int unsigned CountOutBits = 9;

	// Number of work classes.
	localparam int unsigned NumQueues = 3;

	// Command codes.
	typedef enum logic {
		CMD_PUSH = 1'b0,
		CMD_POP  = 1'b1
	} cmd_code_t;

	// Ray class codes. The queue index equals the class code.
	typedef enum logic [1:0] {
		KIND_INTERSECT  = 2'd0,
		KIND_ILLUMINATE = 2'd1,
		KIND_LIGHT      = 2'd2,
		KIND_UNKNOWN    = 2'd3
	} kind_t;

	// Result status codes.
	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_UNKNOWN = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	// Controller states.
	typedef enum logic [1:0] {
		S_IDLE  = 2'd0,
		S_EXEC  = 2'd1,
		S_REPLY = 2'd2
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_cmd_t;

endpackage

// File: hw/rtl/tcprq_ctrl.sv
// ----------------------------------------------------------------------------
// tcprq_ctrl
// Controller for the ray queue: accepts a word, runs the queue update,
// then presents the result for one cycle.
// ----------------------------------------------------------------------------
module tcprq_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	output tcprq_pkg::ctrl_cmd_t  cmd
);

	tcprq_pkg::state_t state_q;
	tcprq_pkg::state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcprq_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tcprq_pkg::S_IDLE: begin
				if (start) begin
					state_d = tcprq_pkg::S_EXEC;
				end
			end
			tcprq_pkg::S_EXEC: begin
				state_d = tcprq_pkg::S_REPLY;
			end
			tcprq_pkg::S_REPLY: begin
				state_d = tcprq_pkg::S_IDLE;
			end
			default: begin
				state_d = tcprq_pkg::S_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		busy     = 1'b1;
		done     = 1'b0;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		case (state_q)
			tcprq_pkg::S_IDLE: begin
				busy     = 1'b0;
				cmd.load = start;
			end
			tcprq_pkg::S_EXEC: begin
				cmd.exec = 1'b1;
			end
			tcprq_pkg::S_REPLY: begin
				done = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

endmodule

// File: hw/rtl/tcprq_dpath.sv
// ----------------------------------------------------------------------------
// tcprq_dpath
// Datapath for the ray queue: three circular buffers with head and tail
// pointers and occupancy counts, strict-priority pop selection.
// ----------------------------------------------------------------------------
module tcprq_dpath #(
	parameter int unsigned QUEUE_DEPTH = tcprq_pkg::DefQueueDepth,
	parameter int unsigned HANDLE_BITS = tcprq_pkg::DefHandleBits
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  tcprq_pkg::ctrl_cmd_t                  cmd,
	input  logic                                  command,
	input  logic [1:0]                            ray_kind,
	input  logic [HANDLE_BITS-1:0]                ray_handle,
	output logic [1:0]                            status,
	output logic                                  out_valid,
	output logic [HANDLE_BITS-1:0]                out_handle,
	output logic [1:0]                            out_kind,
	output logic [tcprq_pkg::CountOutBits-1:0]    light_count,
	output logic [tcprq_pkg::CountOutBits-1:0]    illuminate_count,
	output logic [tcprq_pkg::CountOutBits-1:0]    intersect_count
);

	localparam int unsigned PtrBits = $clog2(QUEUE_DEPTH);
	localparam int unsigned CntBits = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned NQ      = tcprq_pkg::NumQueues;
	localparam int unsigned OutBits = tcprq_pkg::CountOutBits;
	localparam logic [PtrBits-1:0] LastSlot = PtrBits'(QUEUE_DEPTH - 1);
	localparam logic [CntBits-1:0] FullCount = CntBits'(QUEUE_DEPTH);

	// Captured request word.
	logic                   command_q;
	logic [1:0]             kind_q;
	logic [HANDLE_BITS-1:0] handle_q;

	// Queue control state.
	logic [PtrBits-1:0] head_q [NQ];
	logic [PtrBits-1:0] tail_q [NQ];
	logic [CntBits-1:0] cnt_q  [NQ];

	// Registered read data of each buffer and registered result fields.
	logic [HANDLE_BITS-1:0] rd_q [NQ];
	logic [1:0]             status_q;
	logic                   valid_q;
	logic [1:0]             sel_q;

	// Decode signals.
	logic [3:0] full_vec;
	logic [2:0] nonempty;
	logic       push_ok;
	logic       pop_ok;
	logic [1:0] pop_sel;
	logic [1:0] status_d;
	logic [2:0] push_en;
	logic [2:0] pop_en;

	// Wrapping pointer increment.
	function automatic logic [PtrBits-1:0] next_slot(input logic [PtrBits-1:0] p);
		next_slot = (p == LastSlot) ? '0 : p + PtrBits'(1);
	endfunction

	// Capture the request word when it is accepted.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			command_q <= command;
			kind_q    <= ray_kind;
			handle_q  <= ray_handle;
		end
	end

	// Push and pop decode with strict priority: light, illuminate, intersect.
	always_comb begin
		full_vec = 4'b1000;
		for (int i = 0; i < NQ; i++) begin
			full_vec[i] = (cnt_q[i] == FullCount);
			nonempty[i] = (cnt_q[i] != '0);
		end
		push_ok = (command_q == tcprq_pkg::CMD_PUSH) &&
			(kind_q != tcprq_pkg::KIND_UNKNOWN) && !full_vec[kind_q];
		pop_ok  = (command_q == tcprq_pkg::CMD_POP) && (|nonempty);
		if (nonempty[tcprq_pkg::KIND_LIGHT]) begin
			pop_sel = tcprq_pkg::KIND_LIGHT;
		end else if (nonempty[tcprq_pkg::KIND_ILLUMINATE]) begin
			pop_sel = tcprq_pkg::KIND_ILLUMINATE;
		end else begin
			pop_sel = tcprq_pkg::KIND_INTERSECT;
		end
		if (command_q == tcprq_pkg::CMD_PUSH) begin
			if (kind_q == tcprq_pkg::KIND_UNKNOWN) begin
				status_d = tcprq_pkg::ST_UNKNOWN;
			end else if (full_vec[kind_q]) begin
				status_d = tcprq_pkg::ST_FULL;
			end else begin
				status_d = tcprq_pkg::ST_OK;
			end
		end else begin
			status_d = pop_ok ? tcprq_pkg::ST_OK : tcprq_pkg::ST_EMPTY;
		end
		for (int i = 0; i < NQ; i++) begin
			push_en[i] = push_ok && (kind_q == 2'(i));
			pop_en[i]  = pop_ok && (pop_sel == 2'(i));
		end
	end

	// One buffer per class with its pointers and count.
	for (genvar g = 0; g < NQ; g++) begin : g_queue
		logic [HANDLE_BITS-1:0] mem [QUEUE_DEPTH];

		// Buffer write at the tail, registered read at the head.
		always_ff @(posedge clk) begin
			if (cmd.exec) begin
				if (push_en[g]) begin
					mem[tail_q[g]] <= handle_q;
				end
				rd_q[g] <= mem[head_q[g]];
			end
		end

		// Pointer and count update.
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				head_q[g] <= '0;
				tail_q[g] <= '0;
				cnt_q[g]  <= '0;
			end else if (cmd.exec) begin
				if (push_en[g]) begin
					tail_q[g] <= next_slot(tail_q[g]);
					cnt_q[g]  <= cnt_q[g] + CntBits'(1);
				end else if (pop_en[g]) begin
					head_q[g] <= next_slot(head_q[g]);
					cnt_q[g]  <= cnt_q[g] - CntBits'(1);
				end
			end
		end
	end

	// Result fields for the reply cycle.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q <= status_d;
			valid_q  <= pop_ok;
			sel_q    <= pop_ok ? pop_sel : 2'(tcprq_pkg::KIND_INTERSECT);
		end
	end

	// Counts are reported in a fixed-width field, zero-extended or truncated.
	logic [CntBits+OutBits-1:0] light_ext;
	logic [CntBits+OutBits-1:0] illum_ext;
	logic [CntBits+OutBits-1:0] isect_ext;

	assign light_ext = {{OutBits{1'b0}}, cnt_q[tcprq_pkg::KIND_LIGHT]};
	assign illum_ext = {{OutBits{1'b0}}, cnt_q[tcprq_pkg::KIND_ILLUMINATE]};
	assign isect_ext = {{OutBits{1'b0}}, cnt_q[tcprq_pkg::KIND_INTERSECT]};

	assign light_count      = light_ext[OutBits-1:0];
	assign illuminate_count = illum_ext[OutBits-1:0];
	assign intersect_count  = isect_ext[OutBits-1:0];

	// Popped handle comes from the buffer that was selected.
	assign status     = status_q;
	assign out_valid  = valid_q;
	assign out_kind   = sel_q;
	assign out_handle = valid_q ? rd_q[sel_q] : '0;

endmodule

// File: hw/rtl/three_class_priority_ray_queue.sv
// ----------------------------------------------------------------------------
// three_class_priority_ray_queue
// Strict-priority ray work queue with three classes: light, illuminate and
// intersect. Pops serve light first, then illuminate, then intersect.
//
//   Channel   Handshake               Word
//   --------  ----------------------  -----------------------------------------
//   request   start high, busy low    command, ray_kind, ray_handle
//   result    done high, one cycle    status, out_valid, out_handle, out_kind,
//                                     light_count, illuminate_count,
//                                     intersect_count
//
// Each accepted word goes through capture, queue update with the
// buffer read at the head, and the result cycle with done high.
// The buffers have one write and one registered read port each, which sets
// the update and result cycles. busy stays high from capture until done.
// Reset clears pointers and counts at once; no clearing pass is needed.
// The receiver cannot stall the result.
// ----------------------------------------------------------------------------
module three_class_priority_ray_queue #(
	parameter int unsigned QUEUE_DEPTH = tcprq_pkg::DefQueueDepth,
	parameter int unsigned HANDLE_BITS = tcprq_pkg::DefHandleBits
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  start,
	output logic                                  busy,
	input  logic                                  command,
	input  logic [1:0]                            ray_kind,
	input  logic [HANDLE_BITS-1:0]                ray_handle,
	output logic                                  done,
	output logic [1:0]                            status,
	output logic                                  out_valid,
	output logic [HANDLE_BITS-1:0]                out_handle,
	output logic [1:0]                            out_kind,
	output logic [tcprq_pkg::CountOutBits-1:0]    light_count,
	output logic [tcprq_pkg::CountOutBits-1:0]    illuminate_count,
	output logic [tcprq_pkg::CountOutBits-1:0]    intersect_count
);

	tcprq_pkg::ctrl_cmd_t cmd;

	// Sequencing.
	tcprq_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	// Queue storage and selection.
	tcprq_dpath #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.HANDLE_BITS (HANDLE_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.command          (command),
		.ray_kind         (ray_kind),
		.ray_handle       (ray_handle),
		.status           (status),
		.out_valid        (out_valid),
		.out_handle       (out_handle),
		.out_kind         (out_kind),
		.light_count      (light_count),
		.illuminate_count (illuminate_count),
		.intersect_count  (intersect_count)
	);

endmodule

// File: hw/rtl/tcprq_checker.sv
// ----------------------------------------------------------------------------
// tcprq_checker
// Port-level checks for the ray queue, bound to the top level.
// ----------------------------------------------------------------------------
module tcprq_checker #(
	parameter int unsigned HANDLE_BITS = tcprq_pkg::DefHandleBits
) (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  start,
	input logic                                  busy,
	input logic                                  done,
	input logic [1:0]                            status,
	input logic                                  out_valid,
	input logic [HANDLE_BITS-1:0]                out_handle,
	input logic [tcprq_pkg::CountOutBits-1:0]    light_count,
	input logic [tcprq_pkg::CountOutBits-1:0]    illuminate_count,
	input logic [tcprq_pkg::CountOutBits-1:0]    intersect_count
);

	// An accepted word makes the block busy in the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// A result appears only once an accepted word has passed through the EXEC state.
	a_done_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 2))
		else $error("result without a matching accepted word");

	// A returned ray always reports a good status.
	a_valid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && out_valid) |-> (status == tcprq_pkg::ST_OK))
		else $error("returned ray with a bad status");

	// No returned ray means a zero handle.
	a_handle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !out_valid) |-> (out_handle == '0))
		else $error("nonzero handle without a returned ray");

	// An empty report means all three queues are empty.
	a_empty_counts: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == tcprq_pkg::ST_EMPTY) |->
		(light_count == '0 && illuminate_count == '0 && intersect_count == '0))
		else $error("empty status with queued rays");

endmodule

bind three_class_priority_ray_queue tcprq_checker #(
	.HANDLE_BITS (HANDLE_BITS)
) u_tcprq_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.start            (start),
	.busy             (busy),
	.done             (done),
	.status           (status),
	.out_valid        (out_valid),
	.out_handle       (out_handle),
	.light_count      (light_count),
	.illuminate_count (illuminate_count),
	.intersect_count  (intersect_count)
);
